[hw/rtl/pmfd_pkg.sv]
// shared constants and types for the meter frame decoder
`timescale 1ns / 1ps
package pmfd_pkg;
  localparam int FrameLen = 24;
  localparam logic [7:0] HeadSync = 8'h55;
  localparam logic [7:0] HeadMin = 8'hF0;
  localparam logic [7:0] SecondSync = 8'h5A;
  localparam logic [7:0] HeadCal = 8'hAA;
  localparam logic [7:0] FaultMask = 8'hFC;
  localparam logic [7:0] NoPowerMask = 8'hF2;
  localparam logic [7:0] AdjVolt = 8'h40;
  localparam logic [7:0] AdjPower = 8'h10;
  localparam logic [7:0] AdjCurr = 8'h20;
  localparam logic [62:0] Max63 = {63{1'b1}};

  localparam logic [2:0] RegRatioV = 3'd0;
  localparam logic [2:0] RegRatioC = 3'd1;
  localparam logic [2:0] RegRatioP = 3'd2;
  localparam logic [2:0] RegCurrDiv = 3'd3;
  localparam logic [2:0] RegVoltDiv = 3'd4;
  localparam logic [2:0] RegTimeout = 3'd5;

  localparam logic [1:0] StatOk = 2'd0;
  localparam logic [1:0] StatSum = 2'd1;
  localparam logic [1:0] StatCal = 2'd2;
  localparam logic [1:0] StatFault = 2'd3;

  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;
endpackage

[hw/rtl/pmfd_div.sv]
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module pmfd_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [39:0]        dividend,
  input  logic [23:0]        divisor,
  output pmfd_pkg::div_ctl_t ctl,
  output logic [39:0]        quotient
);
  logic [24:0] rem;
  logic [39:0] q;
  logic [23:0] dvs;
  logic [5:0]  cnt;
  logic        busy;
  logic [24:0] trial;

  assign trial = {rem[23:0], q[39]} - {1'b0, dvs};
  assign ctl.start = start;
  assign ctl.busy = busy;
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= 6'd40;
      rem <= '0;
      q <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[24]) begin
        rem <= trial;
        q <= {q[38:0], 1'b1};
      end else begin
        rem <= {rem[23:0], q[39]};
        q <= {q[38:0], 1'b0};
      end
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) busy <= 1'b0;
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (rst)
    busy && !start && cnt == 6'd1 |=> !ctl.busy) else $error("div end");
  a_idle: assert property (@(posedge clk) disable iff (rst)
    !busy && !start |=> !busy) else $error("div spurious");
  a_start: assert property (@(posedge clk) disable iff (rst)
    start |=> busy && cnt == 6'd40) else $error("div start");
endmodule

[hw/rtl/power_meter_frame_decoder.sv]
// meter frame decoder top level: byte assembly, frame check and scaling
// processing: a byte that does not end a frame is taken in S_IDLE; a frame-ending byte starts
// a serial checksum, and a rejected frame goes to output after it; a good frame then gets, per
// quantity, a shift-add multiply and three divides, then an energy multiply
// throughput: one byte per cycle while idle (ready only in S_IDLE); one frame end at a time
// reset: synchronous rst clears position, pulses, energy and held values; config goes to defaults
`timescale 1ns / 1ps
module power_meter_frame_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // rx_byte[7:0], gap_ms[23:8]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [167:0] m_axis_tdata,  // voltage_out, current_out, power_out, energy_out
  output logic [1:0]  m_axis_tuser,   // status
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  typedef enum logic [3:0] {
    S_IDLE, S_SUM, S_MUL, S_DSTART, S_DWAIT, S_NEXT, S_EMUL, S_EADD, S_OUT
  } state_t;

  state_t state;
  logic [15:0] ratio_v, ratio_c, ratio_p, cdiv, vdiv, tmo;
  logic [7:0]  fs [pmfd_pkg::FrameLen];
  logic [4:0]  pos;
  logic [15:0] prev_pulses;
  logic [62:0] energy;
  logic [31:0] held_v, held_c, held_p;

  logic [4:0]  idx;
  logic [7:0]  sum;
  logic [1:0]  qsel;      // 0 voltage, 1 power, 2 current
  logic [2:0]  dstep;     // which divide in the chain
  logic [39:0] acc;       // product / running quotient
  logic [15:0] mreg;
  logic [23:0] mcand;
  logic [4:0]  mcnt;
  logic        zero_q;
  logic [39:0] ebuf;      // energy product
  logic [23:0] ecand;
  logic [15:0] emul;
  logic        div_start;
  logic [23:0] div_d;
  logic [39:0] div_q;
  pmfd_pkg::div_ctl_t div_ctl;

  logic [7:0]  rx;
  logic [15:0] gap;
  logic [4:0]  p0;
  logic        head_ok;

  assign rx = s_axis_tdata[7:0];
  assign gap = s_axis_tdata[23:8];
  assign s_axis_tready = (state == S_IDLE);
  assign p0 = (gap > tmo || pos >= 5'(pmfd_pkg::FrameLen)) ? 5'd0 : pos;
  assign head_ok = rx == pmfd_pkg::HeadSync || rx >= pmfd_pkg::HeadMin;

  function automatic logic [23:0] f24(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    f24 = {a, b, c};
  endfunction

  logic [23:0] coef, cyc;
  logic [15:0] rat, d1, d2;
  logic        gate;
  always_comb begin
    coef = f24(fs[2], fs[3], fs[4]);
    cyc = f24(fs[5], fs[6], fs[7]);
    rat = ratio_v;
    d1 = vdiv;
    d2 = 16'd1;
    gate = (fs[20] & pmfd_pkg::AdjVolt) != 8'd0;
    case (qsel)
      2'd1: begin
        coef = f24(fs[14], fs[15], fs[16]);
        cyc = f24(fs[17], fs[18], fs[19]);
        rat = ratio_p;
        d1 = cdiv;
        d2 = vdiv;
        gate = (fs[20] & pmfd_pkg::AdjPower) != 8'd0 &&
               (fs[0] & pmfd_pkg::NoPowerMask) != pmfd_pkg::NoPowerMask;
      end
      2'd2: begin
        coef = f24(fs[8], fs[9], fs[10]);
        cyc = f24(fs[11], fs[12], fs[13]);
        rat = ratio_c;
        d1 = cdiv;
        d2 = 16'd1;
        gate = (fs[20] & pmfd_pkg::AdjCurr) != 8'd0 && held_p != 32'd0;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (dstep)
      3'd0: div_d = cyc;
      3'd1: div_d = {8'd0, d1};
      default: div_d = {8'd0, d2};
    endcase
  end

  pmfd_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(acc), .divisor(div_d),
    .ctl(div_ctl), .quotient(div_q)
  );

  logic [15:0] pulses;
  logic [15:0] delta;
  logic [63:0] esum;
  assign pulses = {fs[21], fs[22]};
  assign delta = (prev_pulses == 16'd0) ? 16'd0 : pulses - prev_pulses;
  assign esum = {1'b0, energy} + {24'd0, ebuf};

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready &&
        !(p0 == 5'd0 && !head_ok) && !(p0 == 5'd1 && rx != pmfd_pkg::SecondSync)) begin
      fs[p0] <= rx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ratio_v <= 16'd1; ratio_c <= 16'd1; ratio_p <= 16'd1;
      cdiv <= 16'd1; vdiv <= 16'd1; tmo <= 16'd1000;
    end else if (cfg_we) begin
      case (cfg_index)
        pmfd_pkg::RegRatioV: ratio_v <= cfg_data;
        pmfd_pkg::RegRatioC: ratio_c <= cfg_data;
        pmfd_pkg::RegRatioP: ratio_p <= cfg_data;
        pmfd_pkg::RegCurrDiv: cdiv <= cfg_data;
        pmfd_pkg::RegVoltDiv: vdiv <= cfg_data;
        pmfd_pkg::RegTimeout: tmo <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pos <= '0;
      prev_pulses <= '0;
      energy <= '0;
      held_v <= '0; held_c <= '0; held_p <= '0;
      m_axis_tvalid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            if (p0 == 5'd0) begin
              pos <= head_ok ? 5'd1 : 5'd0;
            end else if (p0 == 5'd1) begin
              pos <= (rx == pmfd_pkg::SecondSync) ? 5'd2 : 5'd0;
            end else if (p0 == 5'(pmfd_pkg::FrameLen - 1)) begin
              pos <= '0;
              state <= S_SUM;
              idx <= 5'd2;
              sum <= '0;
            end else begin
              pos <= p0 + 5'd1;
            end
          end
        end
        S_SUM: begin
          if (idx == 5'd23) begin
            if (sum != fs[23]) begin
              m_axis_tuser <= pmfd_pkg::StatSum;
              state <= S_OUT;
              m_axis_tvalid <= 1'b1;
            end else if (fs[0] == pmfd_pkg::HeadCal) begin
              m_axis_tuser <= pmfd_pkg::StatCal;
              state <= S_OUT;
              m_axis_tvalid <= 1'b1;
            end else if ((fs[0] & pmfd_pkg::FaultMask) > pmfd_pkg::HeadMin) begin
              m_axis_tuser <= pmfd_pkg::StatFault;
              state <= S_OUT;
              m_axis_tvalid <= 1'b1;
            end else begin
              m_axis_tuser <= pmfd_pkg::StatOk;
              qsel <= 2'd0;
              state <= S_NEXT;
            end
          end else begin
            sum <= sum + fs[idx];
            idx <= idx + 5'd1;
          end
        end
        S_NEXT: begin
          // set up the multiply for the quantity in qsel
          acc <= '0;
          mreg <= rat;
          mcand <= coef;
          mcnt <= 5'd16;
          zero_q <= !gate || cyc == 24'd0 || d1 == 16'd0 || d2 == 16'd0;
          dstep <= 3'd0;
          state <= S_MUL;
        end
        S_MUL: begin
          // shift-add, one multiplier bit per cycle from the top
          acc <= {acc[38:0], 1'b0} + (mreg[15] ? {16'd0, mcand} : 40'd0);
          mreg <= {mreg[14:0], 1'b0};
          mcnt <= mcnt - 5'd1;
          if (mcnt == 5'd1) state <= S_DSTART;
        end
        S_DSTART: begin
          div_start <= 1'b1;
          state <= S_DWAIT;
        end
        S_DWAIT: begin
          if (!div_start && !div_ctl.busy) begin
            acc <= div_q;
            if (dstep == 3'd2) begin
              if (zero_q) begin
                case (qsel)
                  2'd0: held_v <= '0;
                  2'd1: held_p <= '0;
                  default: held_c <= '0;
                endcase
              end else begin
                case (qsel)
                  2'd0: held_v <= (div_q[39:32] != 8'd0) ? '1 : div_q[31:0];
                  2'd1: held_p <= (div_q[39:32] != 8'd0) ? '1 : div_q[31:0];
                  default: held_c <= (div_q[39:32] != 8'd0) ? '1 : div_q[31:0];
                endcase
              end
              if (qsel == 2'd2) begin
                ebuf <= '0;
                ecand <= f24(fs[14], fs[15], fs[16]);
                emul <= delta;
                mcnt <= 5'd16;
                state <= S_EMUL;
              end else begin
                qsel <= qsel + 2'd1;
                state <= S_NEXT;
              end
            end else begin
              dstep <= dstep + 3'd1;
              state <= S_DSTART;
            end
          end
        end
        S_EMUL: begin
          ebuf <= {ebuf[38:0], 1'b0} + (emul[15] ? {16'd0, ecand} : 40'd0);
          emul <= {emul[14:0], 1'b0};
          mcnt <= mcnt - 5'd1;
          if (mcnt == 5'd1) state <= S_EADD;
        end
        S_EADD: begin
          energy <= esum[63] ? pmfd_pkg::Max63 : esum[62:0];
          prev_pulses <= pulses;
          m_axis_tvalid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = {9'd0, energy, held_p, held_c, held_v};

  a_ready: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("input open during output");
  a_pos: assert property (@(posedge clk) disable iff (rst)
    pos < 5'(pmfd_pkg::FrameLen)) else $error("position range");
  a_energy: assert property (@(posedge clk) disable iff (rst)
    state != S_EADD |=> energy == $past(energy)) else $error("energy moved");
  a_out: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
endmodule
